[rtl/kti_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the knot table interpolator.
package kti_pkg;

  localparam int VAL_W     = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int KIDX_W    = 6;
  localparam int ERR_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KNOT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_BELOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_INSIDE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_ABOVE  = 2'd3;

  localparam logic [CFG_W-1:0] KNOT_COUNT_RST = 7'd2;

  localparam logic [ERR_W-1:0] ERR_OK          = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_WIDTH  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // weight clamp, fixed in LSBs regardless of fraction width
  localparam logic signed [31:0] WGT_LIM = 32'sd1073741824;
  // h^2/6 by reciprocal multiply: ceil(2^34 / 6), exact for any 32-bit operand
  localparam logic [31:0] K_RECIP = 32'hAAAA_AAAB;
  localparam int          K_SHIFT = 34;

  typedef enum logic [1:0] {
    MODE_LINEAR,
    MODE_STEP,
    MODE_SPLINE,
    MODE_UNSUPPORTED
  } mode_t;

  typedef enum logic [2:0] {
    RA_FIRST,
    RA_LAST,
    RA_MID,
    RA_LO,
    RA_HI
  } raddr_sel_t;

  typedef enum logic [3:0] {
    OPND_A,
    OPND_B,
    OPND_R1,
    OPND_R2,
    OPND_Y_LO,
    OPND_Y_HI,
    OPND_Z_LO,
    OPND_Z_HI,
    OPND_H
  } opnd_t;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_T0,
    ACT_REGION,
    ACT_MID,
    ACT_BIS_CMP,
    ACT_CAP_LO,
    ACT_CAP_HI,
    ACT_STEP,
    ACT_H,
    ACT_DIV_B,
    ACT_B,
    ACT_ACC_SET,
    ACT_ACC_ADD,
    ACT_ROUND,
    ACT_Q_R1,
    ACT_Q_R1_CB,
    ACT_Q_R2,
    ACT_Q_R2_CA,
    ACT_Q_ZT,
    ACT_DIV_K,
    ACT_K,
    ACT_Q_LIN,
    ACT_SAT
  } act_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_RD_LAST,
    ST_REGION,
    ST_CHECK,
    ST_BIS_ADDR,
    ST_BIS_CMP,
    ST_RD_LO,
    ST_RD_HI,
    ST_GOT_HI,
    ST_STEP,
    ST_H,
    ST_DIV_B,
    ST_WAIT_B,
    ST_MUL_A,
    ST_MUL_B,
    ST_ACC,
    ST_ROUND,
    ST_SP_BB,
    ST_SP_BB_C,
    ST_SP_BBB,
    ST_SP_CB,
    ST_SP_AA_C,
    ST_SP_AAA,
    ST_SP_CA,
    ST_SP_ZH_C,
    ST_SP_ZT,
    ST_SP_HH_C,
    ST_SP_DIV_K,
    ST_SP_WAIT_K,
    ST_SP_KZ,
    ST_SP_KZ_C,
    ST_SAT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    raddr_sel_t raddr_sel;
    opnd_t      mul_x;
    opnd_t      mul_y;
    act_t       act;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bis_more;
    logic  h_zero;
    logic  div_done;
  } dp_stat_t;

endpackage

[rtl/kti_div.sv]
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module kti_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W:0]   quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic             neg;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den_mag;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_abs;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;

  assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign den_abs = den[DEN_W-1] ? (~den + 1'b1) : den;
  assign rem_sh  = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, den_mag};
  assign rem_sub = rem_sh - {1'b0, den_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && count == CNT_W'(1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo     <= num_mag;
      den_mag <= den_abs;
      rem     <= '0;
      neg     <= num[NUM_W-1] ^ den[DEN_W-1];
      count   <= CNT_W'(NUM_W);
    end else if (busy) begin
      rem   <= fits ? rem_sub : rem_sh;
      quo   <= {quo[NUM_W-2:0], fits};
      count <= count - CNT_W'(1);
    end
  end

  assign quot = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

[rtl/kti_dpath.sv]
`timescale 1ns / 1ps
// Datapath: knot memories, config registers, bisection, weight, multiplier and result.
module kti_dpath
  import kti_pkg::*;
#(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16,
  parameter int EPS_LSBS  = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    cmd,
  input  logic [KIDX_W-1:0]       knot_index,
  input  logic signed [VAL_W-1:0] knot_term,
  input  logic signed [VAL_W-1:0] knot_value,
  input  logic signed [VAL_W-1:0] knot_curvature,
  input  logic signed [VAL_W-1:0] query_term,
  input  logic                    last_query,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  dp_cmd_t                 dp_cmd,
  output dp_stat_t                dp_stat,
  output logic signed [VAL_W-1:0] value,
  output logic [ERR_W-1:0]        error,
  output logic                    last_result
);

  localparam int IW  = $clog2(MAX_KNOTS);
  localparam int CW  = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
  localparam int WXW = IW + KIDX_W;
  localparam int NW  = VAL_W + 1 + FRAC_BITS;
  localparam int QW  = NW + 1;
  localparam logic signed [33:0] EPS  = 34'(EPS_LSBS);
  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [QW-1:0] LIM_Q = QW'(WGT_LIM);
  localparam logic signed [65:0] MAXV = 66'sd2147483647;
  localparam logic signed [65:0] MINV = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    if (x > MAXV) return 32'sh7fffffff;
    if (x < MINV) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [33:0] ext34(input logic signed [31:0] x);
    return {{2{x[31]}}, x};
  endfunction

  // configuration
  logic [CFG_W-1:0] knot_count;
  mode_t            mode_below, mode_inside, mode_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count  <= KNOT_COUNT_RST;
      mode_below  <= MODE_LINEAR;
      mode_inside <= MODE_LINEAR;
      mode_above  <= MODE_LINEAR;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KNOT_COUNT:  knot_count  <= cfg_data;
        CFG_MODE_BELOW:  mode_below  <= mode_t'(cfg_data[1:0]);
        CFG_MODE_INSIDE: mode_inside <= mode_t'(cfg_data[1:0]);
        CFG_MODE_ABOVE:  mode_above  <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  logic [CW-1:0] count_ext;
  logic [IW-1:0] last_idx;

  assign count_ext = CW'(knot_count);

  always_comb begin
    if (count_ext < CW'(2)) begin
      last_idx = IW'(1);
    end else if (count_ext > CW'(MAX_KNOTS)) begin
      last_idx = IW'(MAX_KNOTS - 1);
    end else begin
      last_idx = IW'(count_ext - CW'(1));
    end
  end

  // knot memories
  logic signed [VAL_W-1:0] term_mem  [MAX_KNOTS];
  logic signed [VAL_W-1:0] value_mem [MAX_KNOTS];
  logic signed [VAL_W-1:0] curv_mem  [MAX_KNOTS];
  logic signed [VAL_W-1:0] rd_term, rd_value, rd_curv;
  logic [WXW-1:0] widx_ext;
  logic           widx_ok;
  logic [IW-1:0]  waddr, raddr;
  logic [IW-1:0]  lo, hi, mid, mid_next;

  assign widx_ext = {{IW{1'b0}}, knot_index};
  assign widx_ok  = widx_ext < WXW'(MAX_KNOTS);
  assign waddr    = widx_ext[IW-1:0];
  assign mid_next = IW'(({1'b0, lo} + {1'b0, hi}) >> 1);

  always_comb begin
    case (dp_cmd.raddr_sel)
      RA_FIRST: raddr = '0;
      RA_LAST:  raddr = last_idx;
      RA_MID:   raddr = mid_next;
      RA_LO:    raddr = lo;
      RA_HI:    raddr = hi;
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_WRITE && widx_ok) begin
      term_mem[waddr]  <= knot_term;
      value_mem[waddr] <= knot_value;
      curv_mem[waddr]  <= knot_curvature;
    end
    rd_term  <= term_mem[raddr];
    rd_value <= value_mem[raddr];
    rd_curv  <= curv_mem[raddr];
  end

  // working registers
  logic signed [VAL_W-1:0] q, t0, t_lo, y_lo, z_lo, t_hi, y_hi, z_hi;
  logic signed [VAL_W-1:0] b, a, r1, r2, res_value;
  logic signed [33:0]      key;
  logic signed [32:0]      h, h_next, diff;
  logic signed [63:0]      prod;
  logic [63:0]             kprod;
  logic signed [65:0]      lin, prod_r;
  logic signed [VAL_W-1:0] mul_x_val, mul_y_val, qm, h32, b_sat;
  logic [ERR_W-1:0]        res_err;
  logic                    last_flag;
  mode_t                   mode, region_mode;

  always_comb begin
    if (ext34(q) < ext34(t0) - EPS) begin
      region_mode = mode_below;
    end else if (ext34(q) < ext34(rd_term) + EPS) begin
      region_mode = mode_inside;
    end else begin
      region_mode = mode_above;
    end
  end

  assign h_next = {t_hi[31], t_hi} - {t_lo[31], t_lo};
  assign diff   = {q[31], q} - {t_lo[31], t_lo};
  assign h32    = sat32(66'(h));

  // operand select for the shared multiplier
  function automatic logic signed [31:0] pick(input opnd_t sel);
    case (sel)
      OPND_A:    return a;
      OPND_B:    return b;
      OPND_R1:   return r1;
      OPND_R2:   return r2;
      OPND_Y_LO: return y_lo;
      OPND_Y_HI: return y_hi;
      OPND_Z_LO: return z_lo;
      OPND_Z_HI: return z_hi;
      OPND_H:    return h32;
      default:   return a;
    endcase
  endfunction

  assign mul_x_val = pick(dp_cmd.mul_x);
  assign mul_y_val = pick(dp_cmd.mul_y);

  // fixed multiply: round half up, then saturate
  assign prod_r = (66'(prod) + HALF) >>> FRAC_BITS;
  assign qm     = sat32(prod_r);

  // divider for the weight
  logic              div_start, div_done;
  logic signed [NW-1:0]  div_num;
  logic signed [32:0]    div_den;
  logic signed [QW-1:0]  quot;

  assign div_start = (dp_cmd.act == ACT_DIV_B);
  assign div_num   = {diff, {FRAC_BITS{1'b0}}};
  assign div_den   = h;

  kti_div #(
    .NUM_W (NW),
    .DEN_W (33)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    if (quot > LIM_Q) begin
      b_sat = WGT_LIM;
    end else if (quot < -LIM_Q) begin
      b_sat = -WGT_LIM;
    end else begin
      b_sat = quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_x_val * mul_y_val;
    if (accept) begin
      q         <= query_term;
      last_flag <= last_query;
    end
    case (dp_cmd.act)
      ACT_T0: t0 <= rd_term;
      ACT_REGION: begin
        mode      <= region_mode;
        key       <= (region_mode == MODE_STEP) ? ext34(q) - EPS : ext34(q);
        lo        <= '0;
        hi        <= last_idx;
        res_value <= '0;
        res_err   <= (region_mode == MODE_UNSUPPORTED) ? ERR_UNSUPPORTED : ERR_OK;
      end
      ACT_MID: mid <= mid_next;
      ACT_BIS_CMP: begin
        if (key > ext34(rd_term)) begin
          lo <= mid;
        end else begin
          hi <= mid;
        end
      end
      ACT_CAP_LO: begin
        t_lo <= rd_term;
        y_lo <= rd_value;
        z_lo <= rd_curv;
      end
      ACT_CAP_HI: begin
        t_hi <= rd_term;
        y_hi <= rd_value;
        z_hi <= rd_curv;
      end
      ACT_STEP: res_value <= (key > ext34(t_lo)) ? y_hi : y_lo;
      ACT_H: begin
        h <= h_next;
        if (h_next == '0) begin
          res_err <= ERR_ZERO_WIDTH;
        end
      end
      ACT_B: begin
        b <= b_sat;
        a <= ONE - b_sat;
      end
      ACT_ACC_SET: lin <= 66'(prod);
      ACT_ACC_ADD: lin <= lin + 66'(prod);
      ACT_ROUND:   lin <= (lin + HALF) >>> FRAC_BITS;
      ACT_Q_R1:    r1 <= qm;
      ACT_Q_R1_CB: r1 <= sat32(66'(qm) - 66'(b));
      ACT_Q_R2:    r2 <= qm;
      ACT_Q_R2_CA: r2 <= sat32(66'(qm) - 66'(a));
      ACT_Q_ZT:    r1 <= sat32(66'(r1) + 66'(qm));
      // r2 holds the saturated square of h here, never negative
      ACT_DIV_K:   kprod <= 64'($unsigned(r2)) * 64'(K_RECIP);
      ACT_K:       r2 <= 32'(kprod >> K_SHIFT);
      ACT_Q_LIN:   lin <= lin + 66'(qm);
      ACT_SAT:     res_value <= sat32(lin);
      default: ;
    endcase
    if (dp_cmd.out_load) begin
      value       <= res_value;
      error       <= res_err;
      last_result <= last_flag;
    end
  end

  assign dp_stat.mode     = mode;
  assign dp_stat.bis_more = (hi - lo) > IW'(1);
  assign dp_stat.h_zero   = (h == '0);
  assign dp_stat.div_done = div_done;

  a_bis_order: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.act == ACT_BIS_CMP |=> lo < hi)
    else $error("bisection bracket collapsed");

  a_wgt_clamp: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.act == ACT_B |=> (b <= WGT_LIM && b >= -WGT_LIM))
    else $error("weight outside clamp");

  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    div_start |=> !div_done)
    else $error("divider reports done right after start");

endmodule

[rtl/kti_ctrl.sv]
`timescale 1ns / 1ps
// Controller: request handshake, query sequencing and output register valid.
module kti_ctrl
  import kti_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     cmd,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid && cmd == CMD_QUERY) state_next = ST_RD_FIRST;
      ST_RD_FIRST: state_next = ST_RD_LAST;
      ST_RD_LAST:  state_next = ST_REGION;
      ST_REGION:   state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = (dp_stat.mode == MODE_UNSUPPORTED) ? ST_FINISH : ST_BIS_ADDR;
      end
      ST_BIS_ADDR: state_next = dp_stat.bis_more ? ST_BIS_CMP : ST_RD_LO;
      ST_BIS_CMP:  state_next = ST_BIS_ADDR;
      ST_RD_LO:    state_next = ST_RD_HI;
      ST_RD_HI:    state_next = ST_GOT_HI;
      ST_GOT_HI:   state_next = (dp_stat.mode == MODE_STEP) ? ST_STEP : ST_H;
      ST_STEP:     state_next = ST_FINISH;
      ST_H:        state_next = ST_DIV_B;
      ST_DIV_B:    state_next = dp_stat.h_zero ? ST_FINISH : ST_WAIT_B;
      ST_WAIT_B:   if (dp_stat.div_done) state_next = ST_MUL_A;
      ST_MUL_A:    state_next = ST_MUL_B;
      ST_MUL_B:    state_next = ST_ACC;
      ST_ACC:      state_next = ST_ROUND;
      ST_ROUND:    state_next = (dp_stat.mode == MODE_SPLINE) ? ST_SP_BB : ST_SAT;
      ST_SP_BB:    state_next = ST_SP_BB_C;
      ST_SP_BB_C:  state_next = ST_SP_BBB;
      ST_SP_BBB:   state_next = ST_SP_CB;
      ST_SP_CB:    state_next = ST_SP_AA_C;
      ST_SP_AA_C:  state_next = ST_SP_AAA;
      ST_SP_AAA:   state_next = ST_SP_CA;
      ST_SP_CA:    state_next = ST_SP_ZH_C;
      ST_SP_ZH_C:  state_next = ST_SP_ZT;
      ST_SP_ZT:    state_next = ST_SP_HH_C;
      ST_SP_HH_C:  state_next = ST_SP_DIV_K;
      ST_SP_DIV_K: state_next = ST_SP_WAIT_K;
      ST_SP_WAIT_K: state_next = ST_SP_KZ;
      ST_SP_KZ:    state_next = ST_SP_KZ_C;
      ST_SP_KZ_C:  state_next = ST_SAT;
      ST_SAT:      state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd = '{raddr_sel: RA_FIRST, mul_x: OPND_A, mul_y: OPND_A,
               act: ACT_NONE, out_load: 1'b0};
    case (state)
      ST_RD_LAST: begin
        dp_cmd.raddr_sel = RA_LAST;
        dp_cmd.act       = ACT_T0;
      end
      ST_REGION: dp_cmd.act = ACT_REGION;
      ST_BIS_ADDR: begin
        dp_cmd.raddr_sel = RA_MID;
        dp_cmd.act       = ACT_MID;
      end
      ST_BIS_CMP: dp_cmd.act = ACT_BIS_CMP;
      ST_RD_LO:   dp_cmd.raddr_sel = RA_LO;
      ST_RD_HI: begin
        dp_cmd.raddr_sel = RA_HI;
        dp_cmd.act       = ACT_CAP_LO;
      end
      ST_GOT_HI: dp_cmd.act = ACT_CAP_HI;
      ST_STEP:   dp_cmd.act = ACT_STEP;
      ST_H:      dp_cmd.act = ACT_H;
      ST_DIV_B:  dp_cmd.act = dp_stat.h_zero ? ACT_NONE : ACT_DIV_B;
      ST_WAIT_B: dp_cmd.act = dp_stat.div_done ? ACT_B : ACT_NONE;
      ST_MUL_A: begin
        dp_cmd.mul_x = OPND_A;
        dp_cmd.mul_y = OPND_Y_LO;
      end
      ST_MUL_B: begin
        dp_cmd.mul_x = OPND_B;
        dp_cmd.mul_y = OPND_Y_HI;
        dp_cmd.act   = ACT_ACC_SET;
      end
      ST_ACC:   dp_cmd.act = ACT_ACC_ADD;
      ST_ROUND: dp_cmd.act = ACT_ROUND;
      ST_SP_BB: begin
        dp_cmd.mul_x = OPND_B;
        dp_cmd.mul_y = OPND_B;
      end
      ST_SP_BB_C: dp_cmd.act = ACT_Q_R1;
      ST_SP_BBB: begin
        dp_cmd.mul_x = OPND_R1;
        dp_cmd.mul_y = OPND_B;
      end
      ST_SP_CB: begin
        dp_cmd.act   = ACT_Q_R1_CB;
        dp_cmd.mul_x = OPND_A;
        dp_cmd.mul_y = OPND_A;
      end
      ST_SP_AA_C: dp_cmd.act = ACT_Q_R2;
      ST_SP_AAA: begin
        dp_cmd.mul_x = OPND_R2;
        dp_cmd.mul_y = OPND_A;
      end
      ST_SP_CA: begin
        dp_cmd.act   = ACT_Q_R2_CA;
        dp_cmd.mul_x = OPND_Z_HI;
        dp_cmd.mul_y = OPND_R1;
      end
      ST_SP_ZH_C: begin
        dp_cmd.act   = ACT_Q_R1;
        dp_cmd.mul_x = OPND_Z_LO;
        dp_cmd.mul_y = OPND_R2;
      end
      ST_SP_ZT: begin
        dp_cmd.act   = ACT_Q_ZT;
        dp_cmd.mul_x = OPND_H;
        dp_cmd.mul_y = OPND_H;
      end
      ST_SP_HH_C:   dp_cmd.act = ACT_Q_R2;
      ST_SP_DIV_K:  dp_cmd.act = ACT_DIV_K;
      ST_SP_WAIT_K: dp_cmd.act = ACT_K;
      ST_SP_KZ: begin
        dp_cmd.mul_x = OPND_R2;
        dp_cmd.mul_y = OPND_R1;
      end
      ST_SP_KZ_C: dp_cmd.act = ACT_Q_LIN;
      ST_SAT:     dp_cmd.act = ACT_SAT;
      ST_FINISH:  dp_cmd.out_load = out_free;
      default: ;
    endcase
  end

  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_QUERY) |=> state == ST_RD_FIRST)
    else $error("accepted query did not start a lookup");

  a_wait_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT_B && dp_stat.div_done) |=> state == ST_MUL_A)
    else $error("weight ready but multiply not started");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && !out_valid) |=> (out_valid && state == ST_IDLE))
    else $error("result not moved into an empty output register");

endmodule

[rtl/knot_table_interpolator.sv]
`timescale 1ns / 1ps
// Top level: knot table interpolator, linear / step / cubic spline over a knot table.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   cmd, knot_index, knot_term, knot_value,
//                                             knot_curvature, query_term, last_query
//   out      result     out_valid / out_stall value, error, last_result
//   cfg      write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A knot write is stored as it is accepted, and the controller stays idle. A query reads the
// table through one read port with a bisection, then linear mode runs a bit-serial
// divider for the weight and spline mode adds the curvature terms.
// Step mode ends after the bisection. Results sit in an output register, so a new
// request is taken while a result waits under out_stall. Synchronous reset: knot_count 2,
// all modes linear; the knot table is not cleared.
module knot_table_interpolator
  import kti_pkg::*;
#(
  parameter int MAX_KNOTS = 64,
  parameter int FRAC_BITS = 16,
  parameter int EPS_LSBS  = 7
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    cmd,
  input  logic [KIDX_W-1:0]       knot_index,
  input  logic signed [VAL_W-1:0] knot_term,
  input  logic signed [VAL_W-1:0] knot_value,
  input  logic signed [VAL_W-1:0] knot_curvature,
  input  logic signed [VAL_W-1:0] query_term,
  input  logic                    last_query,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] value,
  output logic [ERR_W-1:0]        error,
  output logic                    last_result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;

  kti_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  kti_dpath #(
    .MAX_KNOTS (MAX_KNOTS),
    .FRAC_BITS (FRAC_BITS),
    .EPS_LSBS  (EPS_LSBS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cmd            (cmd),
    .knot_index     (knot_index),
    .knot_term      (knot_term),
    .knot_value     (knot_value),
    .knot_curvature (knot_curvature),
    .query_term     (query_term),
    .last_query     (last_query),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .value          (value),
    .error          (error),
    .last_result    (last_result)
  );

endmodule

[tb/knot_table_interpolator_tb.sv]
`timescale 1ns / 1ps
// Testbench for the knot table interpolator: random tables, directed and random queries, checked against a predictor.
module knot_table_interpolator_tb;
  import kti_pkg::*;

  localparam int NKNOTS = 64;
  localparam int EPS    = 7;
  localparam int FRAC   = 16;

  class knot_scoreboard;
    longint term_tab[NKNOTS];
    longint val_tab[NKNOTS];
    longint curv_tab[NKNOTS];
    logic [CFG_W-1:0] knot_cnt;
    mode_t mode_lo, mode_mid, mode_hi;
    logic signed [31:0] exp_value[$];
    logic [1:0] exp_error[$];
    logic exp_last[$];
    int mismatches;

    function new();
      knot_cnt = KNOT_COUNT_RST;
      mode_lo = MODE_LINEAR;
      mode_mid = MODE_LINEAR;
      mode_hi = MODE_LINEAR;
      mismatches = 0;
    endfunction

    function int used_knots();
      if (knot_cnt < 2) return 2;
      if (knot_cnt > NKNOTS) return NKNOTS;
      return int'(knot_cnt);
    endfunction

    function longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint round_q(longint x);
      return (x + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function longint fmul(longint a, longint b);
      return sat32(round_q(sat32(a) * sat32(b)));
    endfunction

    function void bracket(longint key, int n, output int lo, output int hi);
      int m;
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        m = (lo + hi) / 2;
        if (key > term_tab[m]) lo = m;
        else hi = m;
      end
    endfunction

    function longint interp(mode_t md, longint q, output logic [1:0] err);
      int n, lo, hi;
      longint one, h, b, a, lin, cb, ca, zt, h32, k;
      n = used_knots();
      one = 64'sd1 <<< FRAC;
      err = ERR_OK;
      if (md == MODE_STEP) begin
        bracket(q - EPS, n, lo, hi);
        return (q - EPS > term_tab[lo]) ? val_tab[hi] : val_tab[lo];
      end
      if (md == MODE_UNSUPPORTED) begin
        err = ERR_UNSUPPORTED;
        return 0;
      end
      bracket(q, n, lo, hi);
      h = term_tab[hi] - term_tab[lo];
      if (h == 0) begin
        err = ERR_ZERO_WIDTH;
        return 0;
      end
      b = ((q - term_tab[lo]) * one) / h;
      if (b > (64'sd1 <<< 30)) b = 64'sd1 <<< 30;
      if (b < -(64'sd1 <<< 30)) b = -(64'sd1 <<< 30);
      a = one - b;
      lin = round_q(a * val_tab[lo] + b * val_tab[hi]);
      if (md == MODE_SPLINE) begin
        cb = sat32(fmul(fmul(b, b), b) - b);
        ca = sat32(fmul(fmul(a, a), a) - a);
        zt = sat32(fmul(curv_tab[hi], cb) + fmul(curv_tab[lo], ca));
        h32 = sat32(h);
        k = fmul(h32, h32) / 6;
        lin += fmul(k, zt);
      end
      return sat32(lin);
    endfunction

    function void note_request(logic c, logic [5:0] idx, logic signed [31:0] t,
                               logic signed [31:0] v, logic signed [31:0] z,
                               logic signed [31:0] q, logic lst);
      longint ql, r;
      int n;
      mode_t md;
      logic [1:0] err;
      if (c == CMD_WRITE) begin
        term_tab[idx] = longint'(t);
        val_tab[idx] = longint'(v);
        curv_tab[idx] = longint'(z);
        return;
      end
      n = used_knots();
      ql = longint'(q);
      if (ql < term_tab[0] - EPS) md = mode_lo;
      else if (ql < term_tab[n-1] + EPS) md = mode_mid;
      else md = mode_hi;
      r = interp(md, ql, err);
      exp_value.push_back(r[31:0]);
      exp_error.push_back(err);
      exp_last.push_back(lst);
    endfunction

    function void check_result(logic signed [31:0] v, logic [1:0] e, logic l);
      if (exp_value.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value=%0d error=%0d", v, e);
        return;
      end
      if (v !== exp_value[0] || e !== exp_error[0] || l !== exp_last[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp value=%0d error=%0d last=%0b, got value=%0d error=%0d last=%0b",
                   exp_value[0], exp_error[0], exp_last[0], v, e, l);
      end
      void'(exp_value.pop_front());
      void'(exp_error.pop_front());
      void'(exp_last.pop_front());
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = CMD_WRITE;
  logic [KIDX_W-1:0] knot_index = '0;
  logic signed [VAL_W-1:0] knot_term = '0;
  logic signed [VAL_W-1:0] knot_value = '0;
  logic signed [VAL_W-1:0] knot_curvature = '0;
  logic signed [VAL_W-1:0] query_term = '0;
  logic last_query = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] value;
  logic [ERR_W-1:0] error;
  logic last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  knot_scoreboard sb = new();
  bit calm = 1'b0;
  int stall_left = 0;

  always #4 clk = ~clk;

  knot_table_interpolator u_dut (.*);

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(value, error, last_result);
      stall_left = calm ? 0 : $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  task automatic send_request(logic c, logic [5:0] idx, logic signed [31:0] t,
                              logic signed [31:0] v, logic signed [31:0] z,
                              logic signed [31:0] q, logic lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    knot_index <= idx;
    knot_term <= t;
    knot_value <= v;
    knot_curvature <= z;
    query_term <= q;
    last_query <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, idx, t, v, z, q, lst);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.exp_value.size() != 0) @(posedge clk);
    // settle time; knot writes are stored as they are accepted
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_KNOT_COUNT:  sb.knot_cnt = d;
      CFG_MODE_BELOW:  sb.mode_lo = mode_t'(d[1:0]);
      CFG_MODE_INSIDE: sb.mode_mid = mode_t'(d[1:0]);
      default:         sb.mode_hi = mode_t'(d[1:0]);
    endcase
  endtask

  task automatic set_modes(logic [CFG_W-1:0] cnt, mode_t b, mode_t m, mode_t a);
    write_reg(CFG_KNOT_COUNT, cnt);
    write_reg(CFG_MODE_BELOW, {5'd0, b});
    write_reg(CFG_MODE_INSIDE, {5'd0, m});
    write_reg(CFG_MODE_ABOVE, {5'd0, a});
  endtask

  // kind 0 ordinary ascending, 1 with repeated terms, 2 raw random, 3 wide steps up from the most negative term
  task automatic load_table(int kind);
    longint t;
    logic signed [31:0] v, z;
    t = (kind == 3) ? -64'sd2147483648 : longint'($signed($urandom_range(0, 1 << 21))) - (1 << 20);
    for (int i = 0; i < NKNOTS; i++) begin
      if (kind == 2) begin
        v = $urandom;
        z = $urandom;
        send_request(CMD_WRITE, 6'(i), $urandom, v, z, '0, 1'b0);
      end else begin
        v = (kind == 3) ? $urandom : $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        z = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        send_request(CMD_WRITE, 6'(i), t[31:0], v, z, '0, 1'b0);
        case (kind)
          1:       t += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 18);
          3:       t += $urandom_range(0, (1 << 26) - 1);
          default: t += $urandom_range(1, 1 << 18);
        endcase
      end
    end
  endtask

  function automatic logic signed [31:0] pick_query();
    int n, i;
    longint q;
    n = sb.used_knots();
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 11))
      0: q = $signed($urandom);
      1: q = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
      2: q = sb.term_tab[0] - 9 + $urandom_range(0, 3);
      3: q = sb.term_tab[n-1] + 5 + $urandom_range(0, 3);
      4: q = sb.term_tab[i] - 8 + $urandom_range(0, 16);
      5: q = sb.term_tab[0] - $urandom_range(0, 1 << 24);
      6: q = sb.term_tab[n-1] + $urandom_range(0, 1 << 24);
      default: q = sb.term_tab[i] + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    endcase
    return 32'(sb.sat32(q));
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 7'($urandom_range(0, 1));
      1: return 7'($urandom_range(65, 127));
      2: return 7'(NKNOTS);
      3: return 7'd2;
      default: return 7'($urandom_range(2, NKNOTS));
    endcase
  endfunction

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int nq;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corner settings, extreme and edge-of-range queries
    load_table(0);
    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: set_modes(NKNOTS, MODE_LINEAR, MODE_LINEAR, MODE_LINEAR);
        1: set_modes(2, MODE_STEP, MODE_SPLINE, MODE_UNSUPPORTED);
        2: set_modes(0, MODE_UNSUPPORTED, MODE_STEP, MODE_SPLINE);
        default: set_modes(127, MODE_SPLINE, MODE_UNSUPPORTED, MODE_STEP);
      endcase
      send_request(CMD_QUERY, '0, '0, '0, '0, 32'sh8000_0000, 1'b0);
      send_request(CMD_QUERY, '0, '0, '0, '0, 32'sh7fff_ffff, 1'b1);
      send_request(CMD_QUERY, '0, '0, '0, '0, 32'(sb.sat32(sb.term_tab[0] - EPS - 1)), 1'b0);
      send_request(CMD_QUERY, '0, '0, '0, '0, 32'(sb.sat32(sb.term_tab[0] - EPS)), 1'b0);
      send_request(CMD_QUERY, '0, '0, '0, '0,
                   32'(sb.sat32(sb.term_tab[sb.used_knots()-1] + EPS - 1)), 1'b1);
      send_request(CMD_QUERY, '0, '0, '0, '0,
                   32'(sb.sat32(sb.term_tab[sb.used_knots()-1] + EPS)), 1'b0);
    end

    // random phases
    for (int p = 0; p < 22; p++) begin
      drain();
      calm = (p == 7 || p == 15);
      if (p == 3) set_modes(NKNOTS, MODE_SPLINE, MODE_SPLINE, MODE_SPLINE);
      else set_modes(pick_count(), mode_t'($urandom_range(0, 3)),
                     mode_t'($urandom_range(0, 3)), mode_t'($urandom_range(0, 3)));
      if (p % 3 == 0) load_table($urandom_range(0, 3));
      nq = 55;
      for (int j = 0; j < nq; j++) begin
        if ($urandom_range(0, 14) == 0)
          send_request(CMD_WRITE, 6'($urandom_range(0, NKNOTS - 1)),
                       $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        send_request(CMD_QUERY, 6'($urandom), $urandom, $urandom, $urandom,
                     pick_query(), 1'($urandom_range(0, 1)));
        // midway through phase 5 the sender holds off until the pipe is empty
        if (p == 5 && j == nq / 2) begin
          in_valid <= 1'b0;
          while (sb.exp_value.size() != 0) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (sb.exp_value.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
